### src/idalloc_pkg.sv
// shared types, codes and constants for the id allocator handle table
package idalloc_pkg;

    // default table depth
    localparam int SLOTS_DEFAULT = 64;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWEST_ID  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGHEST_ID = CFG_INDEX_W'(1);
    localparam logic [31:0] LOWEST_ID_RESET  = 32'h0000_0001;
    localparam logic [31:0] HIGHEST_ID_RESET = 32'hFFFF_FFFF;

    // operation codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED = 3'd3;
    localparam logic [2:0] ST_NOMEM     = 3'd4;
    localparam logic [2:0] ST_NOTFOUND  = 3'd5;

    // input transaction
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] request_id;
        logic [31:0] object_handle;
    } request_t;

    // output transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_id;
        logic [31:0] found_handle;
        logic [6:0]  live_count;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic clear;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic restart;
        logic clr_last;
    } dp_sts_t;

endpackage

### src/idalloc_dp.sv
// datapath: config registers, slot memory, id and count state, result register
module idalloc_dp #(
    parameter int SLOTS = idalloc_pkg::SLOTS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  idalloc_pkg::ctrl_cmd_t                 cmd,
    output idalloc_pkg::dp_sts_t                   sts,
    input  idalloc_pkg::request_t                  request,
    input  logic                                   cfg_we,
    input  logic [idalloc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                            cfg_data,
    output idalloc_pkg::result_t                   result
);
    import idalloc_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = ($clog2(SLOTS + 1) > 7) ? $clog2(SLOTS + 1) : 7;
    localparam logic [31:0] SLOTS_W = 32'(SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);
    localparam logic [CW-1:0] COUNT_SAT = CW'(127);

    // configuration and table state
    logic [31:0]   lowest_reg;
    logic [31:0]   highest_reg;
    logic [31:0]   next_id_reg;
    logic [31:0]   next_id_next;
    logic          no_next_reg;
    logic          no_next_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] clr_addr_reg;

    // captured transaction and read stage
    logic [1:0]    op_reg;
    logic [31:0]   id_reg;
    logic [31:0]   handle_reg;
    logic [AW-1:0] idx_reg;
    logic          in_range_reg;
    logic          fits_reg;
    logic [31:0]   rd_data_reg;
    result_t       result_reg;
    result_t       result_next;

    // slot memory
    logic [31:0]   slot_mem [SLOTS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    logic [31:0]   sel_id;
    logic [31:0]   sel_off;
    logic          sel_in_range;
    logic          sel_fits;
    logic          cfg_restart;
    logic          misconf;
    logic          exec_we;
    logic [31:0]   exec_wdata;

    // a write to a known register restarts the table
    assign cfg_restart = cfg_we && (cfg_index == CFG_LOWEST_ID || cfg_index == CFG_HIGHEST_ID);
    assign sts.restart  = cfg_restart;
    assign sts.clr_last = (clr_addr_reg == LAST_ADDR);

    // slot offset of the id being worked on
    assign sel_id       = (op_reg == OP_ALLOC) ? next_id_reg : id_reg;
    assign sel_off      = sel_id - lowest_reg;
    assign sel_in_range = (sel_id >= lowest_reg) && (sel_id <= highest_reg);
    assign sel_fits     = (sel_off < SLOTS_W);

    // operation decision on the slot contents
    assign misconf = (lowest_reg == 32'd0) || (lowest_reg > highest_reg);

    always_comb
    begin
        result_next  = '0;
        result_next.status = ST_OK;
        count_next   = count_reg;
        next_id_next = next_id_reg;
        no_next_next = no_next_reg;
        exec_we      = 1'b0;
        exec_wdata   = 32'd0;
        if (misconf || !(op_reg inside {OP_ALLOC, OP_LOOKUP, OP_REMOVE}))
        begin
            result_next.status = ST_INVALID;
        end
        else
        begin
            case (op_reg)
                OP_ALLOC:
                begin
                    if (handle_reg == 32'd0)
                    begin
                        result_next.status = ST_INVALID;
                    end
                    else if (no_next_reg || !in_range_reg)
                    begin
                        result_next.status = ST_EXHAUSTED;
                    end
                    else if (!fits_reg)
                    begin
                        result_next.status = ST_NOMEM;
                    end
                    else
                    begin
                        exec_we    = 1'b1;
                        exec_wdata = handle_reg;
                        if (rd_data_reg == 32'd0)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        result_next.granted_id = next_id_reg;
                        if (next_id_reg < highest_reg)
                        begin
                            next_id_next = next_id_reg + 32'd1;
                        end
                        else
                        begin
                            no_next_next = 1'b1;
                        end
                    end
                end
                OP_LOOKUP:
                begin
                    if (!in_range_reg)
                    begin
                        result_next.status = ST_RANGE;
                    end
                    else if (fits_reg)
                    begin
                        result_next.found_handle = rd_data_reg;
                    end
                end
                default:
                begin
                    if (!in_range_reg)
                    begin
                        result_next.status = ST_RANGE;
                    end
                    else if (!fits_reg || rd_data_reg == 32'd0)
                    begin
                        result_next.status = ST_NOTFOUND;
                    end
                    else
                    begin
                        result_next.found_handle = rd_data_reg;
                        exec_we    = 1'b1;
                        exec_wdata = 32'd0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
            endcase
        end
        result_next.live_count = (count_next > COUNT_SAT) ? 7'd127 : count_next[6:0];
    end

    // memory write port: clearing sweep or slot update
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = exec_wdata;
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 32'd0;
        end
        else if (cmd.exec && exec_we)
        begin
            mem_we = 1'b1;
        end
    end

    // slot memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            rd_data_reg <= slot_mem[sel_off[AW-1:0]];
        end
    end

    // captured transaction and read stage flags
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= request.operation;
            id_reg     <= request.request_id;
            handle_reg <= request.object_handle;
        end
        if (cmd.read)
        begin
            idx_reg      <= sel_off[AW-1:0];
            in_range_reg <= sel_in_range;
            fits_reg     <= sel_fits;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    // configuration, allocation state and clearing address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg   <= LOWEST_ID_RESET;
            highest_reg  <= HIGHEST_ID_RESET;
            next_id_reg  <= LOWEST_ID_RESET;
            no_next_reg  <= 1'b0;
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else if (cfg_restart)
        begin
            if (cfg_index == CFG_LOWEST_ID)
            begin
                lowest_reg  <= cfg_data;
                next_id_reg <= cfg_data;
            end
            else
            begin
                highest_reg <= cfg_data;
                next_id_reg <= lowest_reg;
            end
            no_next_reg  <= 1'b0;
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.exec)
            begin
                next_id_reg <= next_id_next;
                no_next_reg <= no_next_next;
                count_reg   <= count_next;
            end
        end
    end

    assign result = result_reg;

endmodule

### src/idalloc_ctrl.sv
// controller: sequences capture, slot read, execute and the clearing sweep
module idalloc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    output logic                    done,
    output idalloc_pkg::ctrl_cmd_t  cmd,
    input  idalloc_pkg::dp_sts_t    sts
);
    import idalloc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        if (sts.restart)
        begin
            state_next = S_CLEAR;
        end
    end

    // commands to the datapath
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.read    = (state_reg == S_READ);
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.clear   = (state_reg == S_CLEAR);

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### src/id_allocator_handle_table_top.sv
// top level of the id allocator handle table
//
//  channel   signals                                 transaction when
//  --------  --------------------------------------  ----------------------------
//  request   start, busy, request                    start && !busy
//  result    done, result                            done (one cycle, no backpressure)
//  config    cfg_valid, cfg_ready, cfg_index, data   cfg_valid && cfg_ready
//
//  each request passes through capture, slot memory read, and execute with write back;
//  the result shows in the cycle after execute, when the next request may already start.
//  after reset and after every write to a known config register a clearing sweep zeroes
//  the slot memory, one entry per cycle, with busy high; config is always
//  ready. the result strobe cannot be stalled.
module id_allocator_handle_table_top #(
    parameter int SLOTS = idalloc_pkg::SLOTS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  idalloc_pkg::request_t                  request,
    output logic                                   done,
    output idalloc_pkg::result_t                   result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [idalloc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                            cfg_data
);
    import idalloc_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;
    logic      cfg_we;

    // config writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    idalloc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    idalloc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

`ifndef SYNTHESIS
    // an accepted request keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a request");

    // a result strobe is never high back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // a failed transaction never carries a granted id
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.granted_id == 32'd0))
        else $error("granted id on a failed transaction");

    // an accepted request without a restarting config write is followed by a result after the read and execute states
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !(cfg_valid && (cfg_index == CFG_LOWEST_ID
            || cfg_index == CFG_HIGHEST_ID))) |=> ##2 done)
        else $error("missing result after accepted request");
`endif

endmodule

### tb/sv/id_allocator_handle_table_top_tb.sv
// testbench for the id allocator handle table: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module id_allocator_handle_table_top_tb;
    import idalloc_pkg::*;

    localparam int TABLE_SLOTS = SLOTS_DEFAULT;
    localparam int SLOT_AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_A = 4'hA;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_B = 4'h5;

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_INDEX_W-1:0]   reg_index;
        logic [31:0]              reg_data;
        request_t                 req;
        bit                       typed;
        result_t                  want;
    } script_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    request_t                 request = '0;
    logic                     done;
    result_t                  result;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [31:0]              cfg_data = '0;

    // mirror of the table state
    logic [31:0]  mirror_lowest_id;
    logic [31:0]  mirror_highest_id;
    logic [31:0]  mirror_slots [TABLE_SLOTS];
    logic [31:0]  mirror_next_id;
    int           mirror_count;
    bit           mirror_no_next;

    result_t      pending_results [$];
    script_row_t  directed_rows [$];
    int           error_count = 0;
    int           cycle_count = 0;

    id_allocator_handle_table_top #(
        .SLOTS(TABLE_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void restart_mirror();
        foreach (mirror_slots[i])
            mirror_slots[i] = '0;
        mirror_count = 0;
        mirror_next_id = mirror_lowest_id;
        mirror_no_next = 1'b0;
    endfunction

    // expected result of one request, updating the mirrored table
    function automatic result_t apply_request(request_t r);
        result_t            res;
        logic [31:0]        off;
        logic [SLOT_AW-1:0] idx;
        res = '0;
        res.status = ST_OK;
        if (mirror_lowest_id == 0 || mirror_lowest_id > mirror_highest_id
            || r.operation == OP_UNUSED)
        begin
            res.status = ST_INVALID;
        end
        else if (r.operation == OP_ALLOC)
        begin
            off = mirror_next_id - mirror_lowest_id;
            idx = off[SLOT_AW-1:0];
            if (r.object_handle == 0)
                res.status = ST_INVALID;
            else if (mirror_no_next || mirror_next_id < mirror_lowest_id
                     || mirror_next_id > mirror_highest_id)
                res.status = ST_EXHAUSTED;
            else if (off >= 32'(TABLE_SLOTS))
                res.status = ST_NOMEM;
            else
            begin
                if (mirror_slots[idx] == 0)
                    mirror_count++;
                mirror_slots[idx] = r.object_handle;
                res.granted_id = mirror_next_id;
                if (mirror_next_id < mirror_highest_id)
                    mirror_next_id++;
                else
                    mirror_no_next = 1'b1;
            end
        end
        else
        begin
            off = r.request_id - mirror_lowest_id;
            idx = off[SLOT_AW-1:0];
            if (r.request_id < mirror_lowest_id || r.request_id > mirror_highest_id)
                res.status = ST_RANGE;
            else if (r.operation == OP_LOOKUP)
            begin
                if (off < 32'(TABLE_SLOTS))
                    res.found_handle = mirror_slots[idx];
            end
            else if (off >= 32'(TABLE_SLOTS) || mirror_slots[idx] == 0)
                res.status = ST_NOTFOUND;
            else
            begin
                res.found_handle = mirror_slots[idx];
                mirror_slots[idx] = '0;
                if (mirror_count != 0)
                    mirror_count--;
            end
        end
        res.live_count = (mirror_count > 127) ? 7'd127 : 7'(mirror_count);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result status", 32'(result.status), '0);
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
                if (result.granted_id !== want.granted_id)
                    report_mismatch("granted_id", result.granted_id, want.granted_id);
                if (result.found_handle !== want.found_handle)
                    report_mismatch("found_handle", result.found_handle, want.found_handle);
                if (result.live_count !== want.live_count)
                    report_mismatch("live_count", 32'(result.live_count),
                                    32'(want.live_count));
            end
        end
    end

    // wait until the table is quiet: no result pending, no clearing sweep
    task automatic drain_table();
        start <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (pending_results.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // one config transaction, only ever issued on a quiet table
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
        drain_table();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == CFG_LOWEST_ID)
        begin
            mirror_lowest_id = data;
            restart_mirror();
        end
        else if (idx == CFG_HIGHEST_ID)
        begin
            mirror_highest_id = data;
            restart_mirror();
        end
        drain_table();
    endtask

    // one request transaction followed by an optional idle burst
    task automatic issue_request(request_t r, bit typed, result_t want, int gap);
        result_t predicted;
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = apply_request(r);
        pending_results.push_back(typed ? want : predicted);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic void add_request(logic [1:0] op, logic [31:0] id, logic [31:0] handle,
                                        bit typed = 1'b0, result_t want = '0);
        script_row_t row;
        row.kind = ROW_REQUEST;
        row.reg_index = '0;
        row.reg_data = '0;
        row.req = '{op, id, handle};
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_config(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
        script_row_t row;
        row.kind = ROW_CONFIG;
        row.reg_index = idx;
        row.reg_data = data;
        row.req = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    // random request, ids mostly near the bottom of the range so slots get hit
    function automatic request_t random_request(int alloc_pct);
        request_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
            r.operation = OP_ALLOC;
        else if (pick >= 96)
            r.operation = OP_UNUSED;
        else
            r.operation = $urandom_range(0, 1) ? OP_LOOKUP : OP_REMOVE;
        case ($urandom_range(0, 9))
            6: r.request_id = $urandom();
            7: r.request_id = mirror_lowest_id - 1;
            8: r.request_id = mirror_highest_id;
            9: r.request_id = mirror_highest_id + 1;
            default: r.request_id = mirror_lowest_id + $urandom_range(0, 70);
        endcase
        case ($urandom_range(0, 19))
            0: r.object_handle = '0;
            1: r.object_handle = '1;
            default: r.object_handle = $urandom();
        endcase
        return r;
    endfunction

    // range settings for the random phases
    task automatic pick_range(int kind, output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom();
        b = $urandom();
        case (kind)
            0:
            begin
                lo = LOWEST_ID_RESET;
                hi = HIGHEST_ID_RESET;
            end
            1:
            begin
                lo = (a == 0) ? 32'd1 : a;
                hi = lo + $urandom_range(0, 90);
                if (hi < lo)
                    hi = '1;
            end
            2:
            begin
                lo = 32'hFFFF_FFFF - $urandom_range(0, 70);
                hi = '1;
            end
            3:
            begin
                lo = (a == 0) ? 32'd1 : a;
                hi = lo;
            end
            4:
            begin
                // broken range: zero bottom or bottom above top
                hi = (b == '1) ? 32'd5 : b;
                lo = $urandom_range(0, 1) ? 32'd0 : hi + 1;
            end
            default:
            begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                if (lo == 0)
                    lo = 32'd1;
            end
        endcase
    endtask

    // stimulus
    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        int          kind;
        int          items;
        int          idle_pct;
        int          alloc_pct;
        int          gap;

        mirror_lowest_id = LOWEST_ID_RESET;
        mirror_highest_id = HIGHEST_ID_RESET;
        restart_mirror();

        // directed part, starting from the reset range
        add_request(OP_LOOKUP, 32'd1, '0, 1, '{ST_OK, '0, '0, 7'd0});
        add_request(OP_LOOKUP, 32'd0, '0, 1, '{ST_RANGE, '0, '0, 7'd0});
        add_request(OP_REMOVE, 32'd1, '0, 1, '{ST_NOTFOUND, '0, '0, 7'd0});
        add_request(OP_ALLOC, 32'd0, '0, 1, '{ST_INVALID, '0, '0, 7'd0});
        add_request(OP_UNUSED, '1, '1, 1, '{ST_INVALID, '0, '0, 7'd0});
        add_request(OP_ALLOC, '1, '1, 1, '{ST_OK, 32'd1, '0, 7'd1});
        add_request(OP_LOOKUP, 32'd1, '0, 1, '{ST_OK, '0, '1, 7'd1});
        add_request(OP_LOOKUP, '1, '0);
        add_request(OP_REMOVE, '1, '0);
        add_request(OP_ALLOC, '0, 32'hA5A5_5A5A);
        // an unmapped register must leave the table alone
        add_config(CFG_UNMAPPED_A, '1);
        add_request(OP_LOOKUP, 32'd2, '0);
        add_request(OP_REMOVE, 32'd1, '0);
        // top of the id space, then exhaustion
        add_config(CFG_LOWEST_ID, 32'hFFFF_FFFE);
        add_request(OP_ALLOC, '0, 32'd1, 1, '{ST_OK, 32'hFFFF_FFFE, '0, 7'd1});
        add_request(OP_ALLOC, '0, 32'd2, 1, '{ST_OK, 32'hFFFF_FFFF, '0, 7'd2});
        add_request(OP_ALLOC, '0, 32'd0, 1, '{ST_INVALID, '0, '0, 7'd2});
        add_request(OP_ALLOC, '0, 32'd3, 1, '{ST_EXHAUSTED, '0, '0, 7'd2});
        add_request(OP_LOOKUP, 32'hFFFF_FFFD, '0, 1, '{ST_RANGE, '0, '0, 7'd2});
        // bottom above top
        add_config(CFG_HIGHEST_ID, 32'hFFFF_FFFD);
        add_request(OP_ALLOC, '0, 32'd5, 1, '{ST_INVALID, '0, '0, 7'd0});
        add_request(OP_LOOKUP, 32'hFFFF_FFFE, '0, 1, '{ST_INVALID, '0, '0, 7'd0});
        // zero bottom
        add_config(CFG_LOWEST_ID, 32'd0);
        add_config(CFG_HIGHEST_ID, '1);
        add_request(OP_REMOVE, 32'd0, '0, 1, '{ST_INVALID, '0, '0, 7'd0});
        // single id range
        add_config(CFG_LOWEST_ID, 32'd7);
        add_config(CFG_HIGHEST_ID, 32'd7);
        add_request(OP_ALLOC, '0, 32'd7, 1, '{ST_OK, 32'd7, '0, 7'd1});
        add_request(OP_ALLOC, '0, 32'd8, 1, '{ST_EXHAUSTED, '0, '0, 7'd1});
        add_request(OP_REMOVE, 32'd7, '0, 1, '{ST_OK, '0, 32'd7, 7'd0});
        add_request(OP_LOOKUP, 32'd7, '0);

        // reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        drain_table();

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
            else
                issue_request(directed_rows[i].req, directed_rows[i].typed,
                              directed_rows[i].want, 0);
        end

        // random phases, each under a fresh range setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            kind = (p < 6) ? p : $urandom_range(0, 5);
            pick_range(kind, lo, hi);
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_LOWEST_ID, lo);
                write_reg(CFG_HIGHEST_ID, hi);
            end
            else
            begin
                write_reg(CFG_HIGHEST_ID, hi);
                write_reg(CFG_LOWEST_ID, lo);
            end
            if (p == 3)
                write_reg(CFG_UNMAPPED_B, $urandom());
            items = (kind == 4) ? 30 : 110;
            idle_pct = (p == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 40);
            alloc_pct = $urandom_range(30, 70);
            for (int n = 0; n < items; n++)
            begin
                gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 14) : 0;
                issue_request(random_request(alloc_pct), 1'b0, '0, gap);
            end
        end

        // wrap up
        drain_table();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
